>>> hdl/sha_pkg.sv
// Package for the SHA-256 digest block: round constants, initial hash values and the controller state type.
package sha_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_LEN,
		ST_DONE
	} state_t;

	localparam logic [31:0] PAD_WORD = 32'h8000_0000;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[t];
	endfunction

endpackage

>>> hdl/sha_round.sv
// One SHA-256 compression round with its message schedule step, shared across all 64 rounds.
module sha_round (
	input  logic [31:0] a, b, c, d, e, f, g, h,
	input  logic [31:0] w_in,
	input  logic [31:0] k_in,
	output logic [31:0] a_next,
	output logic [31:0] e_next,
	input  logic [31:0] w1, w9, w14, w15,
	output logic [31:0] w_new
);
	logic [31:0] big1, big0, ch, maj, x1, s0, s1;

	always_comb begin
		big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
		ch = (e & f) ^ (~e & g);
		x1 = h + big1 + ch + k_in + w_in;
		big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
		maj = (a & b) ^ (a & c) ^ (b & c);
		a_next = x1 + big0 + maj;
		e_next = d + x1;
		// schedule: w[t+16] = w[t] + s0(w[t+1]) + w[t+9] + s1(w[t+14])
		s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
		s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
		w_new = w15 + s0 + w9 + s1;
	end
endmodule

>>> hdl/sha256_digest.sv
// SHA-256 message hasher top level: word intake, padding sequencer and round loop.
// Feed the message as big-endian 32-bit words; valid_bytes counts leading valid bytes and is
// honored only on the word marked final_word (short counts elsewhere count as 4, counts above 4
// saturate). A word that is not final and fills no block is taken with no stall. The word that
// completes a 64-byte block runs the compression: the rounds of the shared round unit, then a
// fold of the working variables into the chaining words, during which stall stays high. On the
// final word the block pads with 0x80, zeros and the 64-bit bit length, which costs one or two
// further compressions, then presents the 256-bit digest as four 64-bit parts held until taken,
// and restarts from the initial hash values. A final word that itself completes a block runs
// that block first and then a padding block of its own. Over a long message the input stalls
// while each block compresses, so throughput is set by the single round unit.
module sha256_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] message_word,
	input  logic [2:0]  valid_bytes,
	input  logic        final_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_part0,
	output logic [63:0] digest_part1,
	output logic [63:0] digest_part2,
	output logic [63:0] digest_part3
);
	sha_pkg::state_t state_q, state_d;

	logic [31:0] chain_q [8];
	logic [31:0] var_q   [8];
	logic [31:0] win_q   [16];	// block buffer, shifted as the schedule window
	logic [5:0]  fill_q;
	logic [60:0] bytes_q;
	logic [5:0]  round_q;
	logic        last_q;	// final word seen, closing compression not yet folded
	logic        two_q;		// padding needs a second block
	logic        pad_q;		// final word closed a full block, padding block still to run
	logic [63:0] dig_q [4];

	logic        in_acc;
	logic [2:0]  cnt;
	logic [31:0] word_m;
	logic [31:0] pad_w;
	logic [5:0]  fill_n;
	logic [60:0] bytes_n;
	logic [31:0] a_next, e_next, w_new;

	assign in_acc = in_valid && !in_stall;

	always_comb begin
		cnt = 3'd4;
		if (final_word && valid_bytes < 3'd4)
			cnt = valid_bytes;
		case (cnt)
			3'd0: word_m = '0;
			3'd1: word_m = {message_word[31:24], 24'd0};
			3'd2: word_m = {message_word[31:16], 16'd0};
			3'd3: word_m = {message_word[31:8], 8'd0};
			default: word_m = message_word;
		endcase
		fill_n = fill_q + {3'd0, cnt};
		bytes_n = bytes_q + {58'd0, cnt};
		// marker byte right after the last message byte
		case (fill_q[1:0])
			2'd0: pad_w = sha_pkg::PAD_WORD;
			2'd1: pad_w = win_q[fill_q[5:2]] | 32'h0080_0000;
			2'd2: pad_w = win_q[fill_q[5:2]] | 32'h0000_8000;
			default: pad_w = win_q[fill_q[5:2]] | 32'h0000_0080;
		endcase
	end

	sha_round u_round (
		.a(var_q[0]), .b(var_q[1]), .c(var_q[2]), .d(var_q[3]),
		.e(var_q[4]), .f(var_q[5]), .g(var_q[6]), .h(var_q[7]),
		.w_in(win_q[0]), .k_in(sha_pkg::round_k(round_q)),
		.a_next(a_next), .e_next(e_next),
		.w1(win_q[1]), .w9(win_q[9]), .w14(win_q[14]), .w15(win_q[0]),
		.w_new(w_new)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (fill_q[5:2] == 4'd15 && cnt == 3'd4)
						state_d = sha_pkg::ST_ROUND;
					else if (final_word)
						state_d = sha_pkg::ST_PAD;
				end
			end
			sha_pkg::ST_ROUND: if (round_q == 6'd63) state_d = sha_pkg::ST_ADD;
			sha_pkg::ST_ADD: begin
				if (!last_q)
					state_d = sha_pkg::ST_IDLE;
				else if (pad_q)
					state_d = sha_pkg::ST_PAD;
				else if (two_q)
					state_d = sha_pkg::ST_LEN;
				else
					state_d = sha_pkg::ST_DONE;
			end
			sha_pkg::ST_PAD: state_d = sha_pkg::ST_ROUND;
			sha_pkg::ST_LEN: state_d = sha_pkg::ST_ROUND;
			sha_pkg::ST_DONE: if (!out_stall) state_d = sha_pkg::ST_IDLE;
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != sha_pkg::ST_IDLE);
		out_valid = (state_q == sha_pkg::ST_DONE);
	end

	assign digest_part0 = dig_q[0];
	assign digest_part1 = dig_q[1];
	assign digest_part2 = dig_q[2];
	assign digest_part3 = dig_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sha_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			bytes_q <= '0;
			round_q <= '0;
			last_q  <= 1'b0;
			two_q   <= 1'b0;
			pad_q   <= 1'b0;
			for (int i = 0; i < 8; i++)
				chain_q[i] <= sha_pkg::init_h(3'(i));
		end else begin
			case (state_q)
				sha_pkg::ST_IDLE: if (in_acc) begin
					fill_q  <= (fill_n == 6'd0 && cnt == 3'd4 && fill_q == 6'd60) ? 6'd0 : fill_n;
					bytes_q <= bytes_n;
					last_q  <= final_word;
					pad_q   <= final_word && fill_q[5:2] == 4'd15 && cnt == 3'd4;
					round_q <= '0;
				end
				sha_pkg::ST_ROUND: round_q <= round_q + 6'd1;
				sha_pkg::ST_ADD: begin
					for (int i = 0; i < 8; i++)
						chain_q[i] <= chain_q[i] + var_q[i];
					if (last_q && !two_q && state_d == sha_pkg::ST_DONE) begin
						fill_q  <= '0;
						bytes_q <= '0;
						last_q  <= 1'b0;
					end
					if (!last_q) begin
						fill_q <= '0;
					end
					two_q <= 1'b0;
				end
				sha_pkg::ST_PAD: begin
					two_q   <= (fill_q[5:2] >= 4'd14);
					pad_q   <= 1'b0;
					round_q <= '0;
				end
				sha_pkg::ST_LEN: round_q <= '0;
				sha_pkg::ST_DONE: if (!out_stall)
					for (int i = 0; i < 8; i++)
						chain_q[i] <= sha_pkg::init_h(3'(i));
				default: ;
			endcase
		end
	end

	// datapath: buffer window, working variables, digest
	always_ff @(posedge clk) begin
		case (state_q)
			sha_pkg::ST_IDLE: if (in_acc) begin
				win_q[fill_q[5:2]] <= word_m;
				for (int i = 0; i < 8; i++)
					var_q[i] <= chain_q[i];
			end
			sha_pkg::ST_ROUND: begin
				var_q[0] <= a_next;
				var_q[1] <= var_q[0];
				var_q[2] <= var_q[1];
				var_q[3] <= var_q[2];
				var_q[4] <= e_next;
				var_q[5] <= var_q[4];
				var_q[6] <= var_q[5];
				var_q[7] <= var_q[6];
				for (int i = 0; i < 15; i++)
					win_q[i] <= win_q[i+1];
				win_q[15] <= w_new;
			end
			sha_pkg::ST_ADD: begin
				for (int i = 0; i < 8; i++)
					var_q[i] <= chain_q[i] + var_q[i];
				if (last_q && two_q) begin
					for (int i = 0; i < 14; i++)
						win_q[i] <= '0;
					win_q[14] <= {bytes_q[60:29]};
					win_q[15] <= {bytes_q[28:0], 3'd0};
				end
				for (int j = 0; j < 4; j++)
					dig_q[j] <= {chain_q[2*j] + var_q[2*j], chain_q[2*j+1] + var_q[2*j+1]};
			end
			sha_pkg::ST_PAD: begin
				// append the marker byte, clear the tail, place the length if it fits
				for (int i = 0; i < 16; i++) begin
					if (i >= 14 && fill_q[5:2] < 4'd14)
						win_q[i] <= (i == 14) ? bytes_q[60:29] : {bytes_q[28:0], 3'd0};
					else if (4'(i) > fill_q[5:2])
						win_q[i] <= '0;
					else if (4'(i) == fill_q[5:2])
						win_q[i] <= pad_w;
				end
			end
			sha_pkg::ST_LEN: ;
			default: ;
		endcase
	end

	// a digest is offered only after a final word started the padding
	a_done_from_add: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == sha_pkg::ST_ADD)
		else $error("digest offered without a closing compression");
	a_round_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_ADD) |-> $past(round_q) == 6'd63)
		else $error("compression folded before 64 rounds");
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_ROUND) |-> in_stall && !out_valid)
		else $error("input taken during rounds");
endmodule
